// ----- rtl/tbpr_pkg.sv -----
// ----------------------------------------------------------------------------
// tbpr_pkg
// Shared types and constants of the tile background pixel renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tbpr_pkg;

  localparam int unsigned VIDEO_MEM_BYTES = 8192;
  localparam int unsigned BANK_WORDS      = VIDEO_MEM_BYTES / 2;
  localparam int unsigned ADDR_W          = $clog2(VIDEO_MEM_BYTES);
  localparam int unsigned WORD_W          = ADDR_W - 1;
  localparam int unsigned CFG_INDEX_W     = 3;

  localparam logic [ADDR_W-1:0] MAP_BASE_LOW        = 13'h1800;
  localparam logic [ADDR_W-1:0] MAP_BASE_HIGH       = 13'h1C00;
  localparam logic [WORD_W-1:0] TILE_SIGNED_WORD_OFS = 12'h400;
  localparam logic [7:0]        TILE_SIGN_FLIP      = 8'h80;

  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCROLL_Y    = 3'd0,
    REG_SCROLL_X    = 3'd1,
    REG_MAP_SELECT  = 3'd2,
    REG_DATA_SELECT = 3'd3,
    REG_SHADE_MAP   = 3'd4,
    REG_BG_ENABLE   = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] scroll_y;
    logic [7:0] scroll_x;
    logic       map_select;
    logic       data_select;
    logic [7:0] shade_map;
    logic       bg_enable;
  } cfg_t;

  typedef struct packed {
    logic              render;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [2:0]        fine_y;
    logic [2:0]        fine_x;
    logic [7:0]        line;
    logic [7:0]        column;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/tbpr_ram.sv -----
// ----------------------------------------------------------------------------
// tbpr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tbpr_front.sv -----
// ----------------------------------------------------------------------------
// tbpr_front
// Input side: accept transactions, apply scroll and form the tile map address.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_front
  import tbpr_pkg::*;
(
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              action_i,
  input  wire logic [ADDR_W-1:0] mem_addr_i,
  input  wire logic [7:0]        mem_data_i,
  input  wire logic [7:0]        screen_line_i,
  input  wire logic [7:0]        screen_column_i,
  input  wire cfg_t              cfg_i,
  input  wire logic              queue_full_i,
  output logic                   push_o,
  output item_t                  item_o
);

  logic [7:0]        pos_y;
  logic [7:0]        pos_x;
  logic [ADDR_W-1:0] map_base;
  logic [ADDR_W-1:0] map_addr;

  assign pos_y    = screen_line_i + cfg_i.scroll_y;
  assign pos_x    = screen_column_i + cfg_i.scroll_x;
  assign map_base = cfg_i.map_select ? MAP_BASE_HIGH : MAP_BASE_LOW;
  assign map_addr = map_base + {3'b000, pos_y[7:3], pos_x[7:3]};

  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i & ~queue_full_i;

  always_comb begin
    item_o.render = (action_i == ACT_RENDER);
    item_o.addr   = (action_i == ACT_RENDER) ? map_addr : mem_addr_i;
    item_o.data   = mem_data_i;
    item_o.fine_y = pos_y[2:0];
    item_o.fine_x = pos_x[2:0];
    item_o.line   = screen_line_i;
    item_o.column = screen_column_i;
  end

endmodule

`default_nettype wire

// ----- rtl/tbpr_queue.sv -----
// ----------------------------------------------------------------------------
// tbpr_queue
// Small FIFO between the input side and the render pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_queue
  import tbpr_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output item_t      item_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == FULL_CNT);
  assign empty_o = (count_q == '0);
  assign item_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tbpr_back.sv -----
// ----------------------------------------------------------------------------
// tbpr_back
// Render pipeline: video memory banks, tile fetch, plane fetch, palette map.
// ----------------------------------------------------------------------------
`default_nettype none

module tbpr_back
  import tbpr_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire item_t item_i,
  input  wire logic  queue_empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output logic [1:0] shade_o,
  output logic [7:0] out_line_o,
  output logic [7:0] out_column_o
);

  logic              advance;
  logic              we_even;
  logic              we_odd;
  logic [7:0]        even_rd_a, even_rd_b;
  logic [7:0]        odd_rd_a, odd_rd_b;
  logic [7:0]        tile;
  logic [WORD_W-1:0] row_word;
  logic [2:0]        bit_sel;
  logic [1:0]        colour;
  logic [1:0]        shade;

  logic       s1_valid_q;
  logic       s1_render_q;
  logic       s1_bank_q;
  logic [2:0] s1_fine_y_q;
  logic [2:0] s1_fine_x_q;
  logic [7:0] s1_line_q;
  logic [7:0] s1_column_q;

  logic       s2_valid_q;
  logic       s2_render_q;
  logic [2:0] s2_fine_x_q;
  logic [7:0] s2_line_q;
  logic [7:0] s2_column_q;

  logic       out_valid_q;
  logic [1:0] shade_q;
  logic [7:0] out_line_q;
  logic [7:0] out_column_q;

  assign advance = ~out_valid_q | ~out_stall_i;
  assign pop_o   = advance & ~queue_empty_i;
  assign we_even = pop_o & ~item_i.render & ~item_i.addr[0];
  assign we_odd  = pop_o & ~item_i.render & item_i.addr[0];

  tbpr_ram #(
    .WIDTH (8),
    .DEPTH (BANK_WORDS)
  ) u_ram_even (
    .clk_i     (clk_i),
    .we_i      (we_even),
    .waddr_i   (item_i.addr[ADDR_W-1:1]),
    .wdata_i   (item_i.data),
    .re_i      (advance),
    .raddr_a_i (item_i.addr[ADDR_W-1:1]),
    .raddr_b_i (row_word),
    .rdata_a_o (even_rd_a),
    .rdata_b_o (even_rd_b)
  );

  tbpr_ram #(
    .WIDTH (8),
    .DEPTH (BANK_WORDS)
  ) u_ram_odd (
    .clk_i     (clk_i),
    .we_i      (we_odd),
    .waddr_i   (item_i.addr[ADDR_W-1:1]),
    .wdata_i   (item_i.data),
    .re_i      (advance),
    .raddr_a_i (item_i.addr[ADDR_W-1:1]),
    .raddr_b_i (row_word),
    .rdata_a_o (odd_rd_a),
    .rdata_b_o (odd_rd_b)
  );

  always_comb begin
    tile = s1_bank_q ? odd_rd_a : even_rd_a;
    if (cfg_i.data_select) begin
      row_word = {1'b0, tile, s1_fine_y_q};
    end else begin
      row_word = {1'b0, tile ^ TILE_SIGN_FLIP, s1_fine_y_q} + TILE_SIGNED_WORD_OFS;
    end
  end

  always_comb begin
    bit_sel = 3'd7 - s2_fine_x_q;
    colour  = {odd_rd_b[bit_sel], even_rd_b[bit_sel]};
    shade   = cfg_i.bg_enable ? cfg_i.shade_map[{colour, 1'b0} +: 2] : 2'b00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= pop_o;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q & s2_render_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_render_q  <= item_i.render;
      s1_bank_q    <= item_i.addr[0];
      s1_fine_y_q  <= item_i.fine_y;
      s1_fine_x_q  <= item_i.fine_x;
      s1_line_q    <= item_i.line;
      s1_column_q  <= item_i.column;
      s2_render_q  <= s1_render_q;
      s2_fine_x_q  <= s1_fine_x_q;
      s2_line_q    <= s1_line_q;
      s2_column_q  <= s1_column_q;
      shade_q      <= shade;
      out_line_q   <= s2_line_q;
      out_column_q <= s2_column_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign shade_o      = shade_q;
  assign out_line_o   = out_line_q;
  assign out_column_o = out_column_q;

endmodule

`default_nettype wire

// ----- rtl/tile_background_pixel_renderer_unit.sv -----
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_unit
// Tile map background renderer with an 8 KiB video memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): action 0 writes mem_data_i to the
// video memory at mem_addr_i and gives no result; action 1 renders the pixel
// at screen_line_i / screen_column_i and gives one result on the output
// channel (out_valid_o / out_stall_i) with the shade and the echoed position.
// Configuration writes use cfg_valid_i / cfg_ready_o with a register index
// and data; ready is always high. Write registers only while no transaction
// is in flight.
// Throughput: one transaction per cycle while the output is not stalled. A
// render result passes the tile number read at the queue pop, then the bit
// plane read, then the shade register; the two video memory reads depend on
// each other.
// A stalled output holds the whole render pipeline; the input queue keeps
// accepting until its QUEUE_DEPTH entries are full, then raises in_stall_o.
// Reset empties the queue and pipeline and loads the register defaults
// (background enabled, everything else zero); video memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_background_pixel_renderer_unit
  import tbpr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [7:0]             cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic                   action_i,
  input  wire logic [ADDR_W-1:0]      mem_addr_i,
  input  wire logic [7:0]             mem_data_i,
  input  wire logic [7:0]             screen_line_i,
  input  wire logic [7:0]             screen_column_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [1:0]                  shade_o,
  output logic [7:0]                  out_line_o,
  output logic [7:0]                  out_column_o
);

  cfg_t  cfg_q;
  item_t push_item;
  item_t head_item;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scroll_y    <= 8'h00;
      cfg_q.scroll_x    <= 8'h00;
      cfg_q.map_select  <= 1'b0;
      cfg_q.data_select <= 1'b0;
      cfg_q.shade_map   <= 8'h00;
      cfg_q.bg_enable   <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SCROLL_Y:    cfg_q.scroll_y    <= cfg_data_i;
        REG_SCROLL_X:    cfg_q.scroll_x    <= cfg_data_i;
        REG_MAP_SELECT:  cfg_q.map_select  <= cfg_data_i[0];
        REG_DATA_SELECT: cfg_q.data_select <= cfg_data_i[0];
        REG_SHADE_MAP:   cfg_q.shade_map   <= cfg_data_i;
        REG_BG_ENABLE:   cfg_q.bg_enable   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  tbpr_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .mem_addr_i      (mem_addr_i),
    .mem_data_i      (mem_data_i),
    .screen_line_i   (screen_line_i),
    .screen_column_i (screen_column_i),
    .cfg_i           (cfg_q),
    .queue_full_i    (q_full),
    .push_o          (q_push),
    .item_o          (push_item)
  );

  tbpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .empty_o (q_empty)
  );

  tbpr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .item_i        (head_item),
    .queue_empty_i (q_empty),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .shade_o       (shade_o),
    .out_line_o    (out_line_o),
    .out_column_o  (out_column_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty && !(out_valid_o && out_stall_i)) |-> q_pop)
    else $error("queue holds work but the pipeline did not take it");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(q_push))
    else $error("input stall raised without a queued transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("pop from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !cfg_q.bg_enable) |-> (shade_o == 2'b00))
    else $error("nonzero shade while background is disabled");

endmodule

`default_nettype wire

// ----- verif/tile_background_pixel_renderer_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_background_pixel_renderer_unit_tb
// Fills the video memory and renders pixels under a series of register
// settings. A short table of directed transactions comes first, then random
// traffic. Every rendered pixel is checked against a behavioral predictor with
// its own copy of the video memory and registers, or against a table-pinned shade.
// Renders read only written bytes; missing map or tile bytes are written first.
// ----------------------------------------------------------------------------
module tile_background_pixel_renderer_unit_tb;
  import tbpr_pkg::*;

  localparam int CLK_PERIOD        = 20;
  localparam int DRAIN_CYCLES      = 32;
  localparam int NO_PROGRESS_LIMIT = 5000;
  localparam int RANDOM_PHASES     = 6;
  localparam int PHASE_ITEMS       = 30;
  localparam int PAUSE_AT          = 15;
  localparam int STEADY_PHASE      = 3;
  localparam int DARK_PHASE        = 4;

  localparam logic [ADDR_W-1:0] SIGNED_TILE_BASE = 13'h0800;

  localparam cfg_t RESET_REGS    = '{8'd0, 8'd0, 1'b0, 1'b0, 8'h00, 1'b1};
  localparam cfg_t FULL_PAL_REGS = '{8'd0, 8'd0, 1'b0, 1'b0, 8'hFF, 1'b1};
  localparam cfg_t IDENTITY_REGS = '{8'd0, 8'd0, 1'b0, 1'b0, 8'hE4, 1'b1};
  localparam cfg_t HIGH_REGS     = '{8'hFF, 8'hFF, 1'b1, 1'b1, 8'h1B, 1'b1};
  localparam cfg_t DARK_REGS     = '{8'd77, 8'd200, 1'b1, 1'b0, 8'hE4, 1'b0};

  typedef struct packed {
    logic [1:0] shade;
    logic [7:0] line;
    logic [7:0] column;
  } pixel_t;

  typedef enum logic [1:0] {ROW_REGS, ROW_WRITE, ROW_RENDER} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    cfg_t              regs;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic [7:0]        line;
    logic [7:0]        column;
    logic              pinned;
    logic [1:0]        shade;
  } step_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_valid_i     = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i     = '0;
  logic [7:0]             cfg_data_i      = '0;
  logic                   in_valid_i      = 1'b0;
  logic                   in_stall_o;
  logic                   action_i        = ACT_WRITE;
  logic [ADDR_W-1:0]      mem_addr_i      = '0;
  logic [7:0]             mem_data_i      = '0;
  logic [7:0]             screen_line_i   = '0;
  logic [7:0]             screen_column_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i     = 1'b0;
  logic [1:0]             shade_o;
  logic [7:0]             out_line_o;
  logic [7:0]             out_column_o;

  cfg_t              regs = RESET_REGS;
  logic [7:0]        vram [VIDEO_MEM_BYTES];
  bit                vram_written [VIDEO_MEM_BYTES];
  pixel_t            expected_pixels [$];
  step_t             directed [$];
  logic [ADDR_W-1:0] last_map_addr = MAP_BASE_LOW;
  logic [ADDR_W-1:0] last_row_addr = '0;
  bit                steady = 1'b0;
  int                mismatches = 0;

  tile_background_pixel_renderer_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .mem_addr_i     (mem_addr_i),
    .mem_data_i     (mem_data_i),
    .screen_line_i  (screen_line_i),
    .screen_column_i(screen_column_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .shade_o        (shade_o),
    .out_line_o     (out_line_o),
    .out_column_o   (out_column_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [ADDR_W-1:0] map_entry_addr(input logic [7:0] y, input logic [7:0] x);
    return (regs.map_select ? MAP_BASE_HIGH : MAP_BASE_LOW) + {3'b000, y[7:3], x[7:3]};
  endfunction

  function automatic logic [ADDR_W-1:0] tile_row_addr(input logic [7:0] tile,
                                                      input logic [2:0] fine_y);
    if (regs.data_select) begin
      return {1'b0, tile, fine_y, 1'b0};
    end
    return SIGNED_TILE_BASE + {1'b0, tile ^ TILE_SIGN_FLIP, fine_y, 1'b0};
  endfunction

  function automatic logic [1:0] predict_shade(input logic [7:0] line, input logic [7:0] column);
    logic [7:0]        y;
    logic [7:0]        x;
    logic [7:0]        plane_lo;
    logic [7:0]        plane_hi;
    logic [ADDR_W-1:0] row;
    logic [1:0]        colour;
    y        = line + regs.scroll_y;
    x        = column + regs.scroll_x;
    row      = tile_row_addr(vram[map_entry_addr(y, x)], y[2:0]);
    plane_lo = vram[row];
    plane_hi = vram[row + 1'b1];
    colour   = {plane_hi[~x[2:0]], plane_lo[~x[2:0]]};
    return regs.bg_enable ? regs.shade_map[colour * 2 +: 2] : 2'd0;
  endfunction

  task automatic send_item(input logic action, input logic [ADDR_W-1:0] addr,
                           input logic [7:0] data, input logic [7:0] line,
                           input logic [7:0] column);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (!steady && $urandom_range(99) < 30);
    end
    in_valid_i      <= 1'b1;
    action_i        <= action;
    mem_addr_i      <= addr;
    mem_data_i      <= data;
    screen_line_i   <= line;
    screen_column_i <= column;
    do @(posedge clk_i); while (in_stall_o);
    if (action == ACT_WRITE) begin
      vram[addr]         = data;
      vram_written[addr] = 1'b1;
    end
  endtask

  task automatic render_pixel(input logic [7:0] line, input logic [7:0] column,
                              input logic pinned, input logic [1:0] shade);
    logic [7:0]        y;
    logic [7:0]        x;
    logic [ADDR_W-1:0] map_addr;
    logic [ADDR_W-1:0] row;
    y        = line + regs.scroll_y;
    x        = column + regs.scroll_x;
    map_addr = map_entry_addr(y, x);
    if (!vram_written[map_addr]) begin
      send_item(ACT_WRITE, map_addr, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    row = tile_row_addr(vram[map_addr], y[2:0]);
    for (int b = 0; b < 2; b++) begin
      if (!vram_written[row + ADDR_W'(b)]) begin
        send_item(ACT_WRITE, row + ADDR_W'(b), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    last_map_addr = map_addr;
    last_row_addr = row;
    send_item(ACT_RENDER, ADDR_W'($urandom), 8'($urandom), line, column);
    expected_pixels.push_back(pixel_t'{pinned ? shade : predict_shade(line, column),
                                       line, column});
  endtask

  task automatic wait_idle();
    bit was_steady;
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    was_steady = steady;
    steady     = 1'b1;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    steady = was_steady;
  endtask

  task automatic program_regs(input cfg_t c);
    logic [7:0] value;
    for (int i = 0; i < (1 << CFG_INDEX_W); i++) begin
      case (cfg_reg_e'(i))
        REG_SCROLL_Y:    value = c.scroll_y;
        REG_SCROLL_X:    value = c.scroll_x;
        REG_MAP_SELECT:  value = {7'($urandom), c.map_select};
        REG_DATA_SELECT: value = {7'($urandom), c.data_select};
        REG_SHADE_MAP:   value = c.shade_map;
        REG_BG_ENABLE:   value = {7'($urandom), c.bg_enable};
        default:         value = 8'($urandom);
      endcase
      cfg_valid_i <= 1'b1;
      cfg_index_i <= i[CFG_INDEX_W-1:0];
      cfg_data_i  <= value;
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    regs = c;
  endtask

  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: pixel line %0d column %0d shade %0d with no transaction pending",
                 $time, out_line_o, out_column_o, shade_o);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (shade_o !== want.shade) begin
          $display("%0t: shade expected %0d actual %0d", $time, want.shade, shade_o);
          mismatches++;
        end
        if (out_line_o !== want.line) begin
          $display("%0t: line expected %0d actual %0d", $time, want.line, out_line_o);
          mismatches++;
        end
        if (out_column_o !== want.column) begin
          $display("%0t: column expected %0d actual %0d", $time, want.column, out_column_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= !steady && ($urandom_range(99) < 30);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < NO_PROGRESS_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tile_background_pixel_renderer_unit test failed");
    $finish;
  end

  initial begin : stimulus
    cfg_t       phase_regs;
    logic [7:0] line;
    logic [7:0] column;
    int         pick;

    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1800, 8'h00, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1000, 8'hA5, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1001, 8'h3C, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd0, 1'b1, 2'd0});
    directed.push_back(step_t'{ROW_REGS, FULL_PAL_REGS, '0, '0, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd0, 1'b1, 2'd3});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd255, 8'd255, 1'b1, 2'd3});
    directed.push_back(step_t'{ROW_REGS, IDENTITY_REGS, '0, '0, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd1, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd2, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd4, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1BFF, 8'h80, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd255, 8'd255, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1FFF, 8'h7F, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_REGS, HIGH_REGS, '0, '0, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd143, 8'd159, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd1, 8'd1, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_REGS, DARK_REGS, '0, '0, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd255, 8'd0, 1'b1, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd255, 1'b1, 2'd0});
    directed.push_back(step_t'{ROW_REGS, IDENTITY_REGS, '0, '0, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1000, 8'hFF, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_WRITE, RESET_REGS, 13'h1800, 8'hFF, '0, '0, 1'b0, 2'd0});
    directed.push_back(step_t'{ROW_RENDER, RESET_REGS, '0, '0, 8'd0, 8'd7, 1'b0, 2'd0});

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[k]) begin
      case (directed[k].kind)
        ROW_REGS: begin
          wait_idle();
          program_regs(directed[k].regs);
        end
        ROW_WRITE: begin
          send_item(ACT_WRITE, directed[k].addr, directed[k].data,
                    8'($urandom), 8'($urandom));
        end
        default: begin
          render_pixel(directed[k].line, directed[k].column,
                       directed[k].pinned, directed[k].shade);
        end
      endcase
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       phase_regs = IDENTITY_REGS;
        1:       phase_regs = '{8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1};
        default: phase_regs = '{8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                                8'($urandom), 1'(phase != DARK_PHASE)};
      endcase
      wait_idle();
      program_regs(phase_regs);
      steady = (phase == STEADY_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PAUSE_AT) begin
          wait_idle();
        end
        pick = $urandom_range(99);
        if (pick < 55) begin
          line   = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(143));
          column = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(159));
          render_pixel(line, column, 1'b0, 2'd0);
        end else if (pick < 70) begin
          send_item(ACT_WRITE, last_row_addr + ADDR_W'($urandom_range(1)), 8'($urandom),
                    8'($urandom), 8'($urandom));
        end else if (pick < 80) begin
          send_item(ACT_WRITE, last_map_addr, 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_item(ACT_WRITE, ADDR_W'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
    end
    steady = 1'b0;

    wait_idle();
    if (mismatches == 0) begin
      $display("tile_background_pixel_renderer_unit test passed");
    end else begin
      $display("tile_background_pixel_renderer_unit test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/tbpr_pkg.sv
rtl/tbpr_ram.sv
rtl/tbpr_front.sv
rtl/tbpr_queue.sv
rtl/tbpr_back.sv
rtl/tile_background_pixel_renderer_unit.sv
verif/tile_background_pixel_renderer_unit_tb.sv
